// ===== rtl/knn_pkg.sv =====
// ----------------------------------------------------------------------------
// knn_pkg
// Shared widths, types and register codes for the k-NN vote classifier.
// ----------------------------------------------------------------------------
package knn_pkg;

	localparam int MAX_K       = 8;
	localparam int MAX_CLASSES = 16;

	localparam int DIST_W  = 16;
	localparam int LABEL_W = 4;
	localparam int NCLS_W  = 5;
	localparam int NBR_W   = 4;
	localparam int CNT_W   = $clog2(MAX_K + 1);
	localparam int CFG_W   = 5;
	localparam int REG_IDX_W = 1;

	// levels of the pairwise max tree over the class counts
	localparam int CLS_LVLS = $clog2(MAX_CLASSES);

	localparam logic [REG_IDX_W-1:0] REG_NUM_CLASSES    = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_NEIGHBOR_COUNT = 1'd1;

	localparam logic [NCLS_W-1:0] NUM_CLASSES_RST    = 5'd2;
	localparam logic [NBR_W-1:0]  NEIGHBOR_COUNT_RST = 4'd5;

	typedef struct packed {
		logic [DIST_W-1:0]  distance;
		logic [LABEL_W-1:0] label;
		logic               last;
	} item_t;

	typedef logic [MAX_K-1:0][LABEL_W-1:0]     label_vec_t;
	typedef logic [MAX_CLASSES-1:0][CNT_W-1:0] count_vec_t;

endpackage

// ===== rtl/knn_list.sv =====
// ----------------------------------------------------------------------------
// knn_list
// Sorted list of the k smallest distances; one parallel compare-and-shift
// insertion per transaction, cleared after the last item of a run.
// ----------------------------------------------------------------------------
module knn_list (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fire,
	input  knn_pkg::item_t            item,
	input  logic [knn_pkg::CNT_W-1:0] k_eff,
	output knn_pkg::label_vec_t       snap_label,
	output logic [knn_pkg::CNT_W-1:0] snap_count
);

	logic [knn_pkg::DIST_W-1:0]  dist_q  [knn_pkg::MAX_K];
	logic [knn_pkg::LABEL_W-1:0] label_q [knn_pkg::MAX_K];
	logic [knn_pkg::CNT_W-1:0]   kept_q;

	logic [knn_pkg::CNT_W-1:0]   n_used;
	logic [knn_pkg::MAX_K-1:0]   gt;
	logic [knn_pkg::DIST_W-1:0]  dist_nx  [knn_pkg::MAX_K];
	logic [knn_pkg::LABEL_W-1:0] label_nx [knn_pkg::MAX_K];

	assign n_used = (kept_q > k_eff) ? k_eff : kept_q;

	// gt[i]: the new item goes at or before slot i (monotonic over i)
	always_comb begin
		for (int i = 0; i < knn_pkg::MAX_K; i++) begin
			gt[i] = (knn_pkg::CNT_W'(i) >= n_used) || (dist_q[i] > item.distance);
		end
	end

	always_comb begin
		for (int i = 0; i < knn_pkg::MAX_K; i++) begin
			if (gt[i] && (i == 0 || !gt[(i == 0) ? 0 : i - 1])) begin
				dist_nx[i]  = item.distance;
				label_nx[i] = item.label;
			end else if (i > 0 && gt[(i == 0) ? 0 : i - 1]) begin
				dist_nx[i]  = dist_q[(i == 0) ? 0 : i - 1];
				label_nx[i] = label_q[(i == 0) ? 0 : i - 1];
			end else begin
				dist_nx[i]  = dist_q[i];
				label_nx[i] = label_q[i];
			end
		end
	end

	// a full list stays full (tail drops off or item is dropped)
	assign snap_count = (n_used == k_eff) ? k_eff : n_used + knn_pkg::CNT_W'(1);

	always_comb begin
		for (int i = 0; i < knn_pkg::MAX_K; i++) begin
			snap_label[i] = label_nx[i];
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			for (int i = 0; i < knn_pkg::MAX_K; i++) begin
				dist_q[i]  <= dist_nx[i];
				label_q[i] <= label_nx[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q <= '0;
		end else if (fire) begin
			kept_q <= item.last ? '0 : snap_count;
		end
	end

endmodule

// ===== rtl/knn_tally.sv =====
// ----------------------------------------------------------------------------
// knn_tally
// Per-class vote counts over the kept entries of one run.
// ----------------------------------------------------------------------------
module knn_tally (
	input  knn_pkg::label_vec_t        labels,
	input  logic [knn_pkg::CNT_W-1:0]  count,
	input  logic [knn_pkg::NCLS_W-1:0] ncls,
	output knn_pkg::count_vec_t        votes
);

	always_comb begin
		for (int c = 0; c < knn_pkg::MAX_CLASSES; c++) begin
			votes[c] = '0;
			for (int i = 0; i < knn_pkg::MAX_K; i++) begin
				if ((knn_pkg::CNT_W'(i) < count) &&
				    (labels[i] == knn_pkg::LABEL_W'(c)) &&
				    (knn_pkg::NCLS_W'(c) < ncls)) begin
					votes[c] = votes[c] + knn_pkg::CNT_W'(1);
				end
			end
		end
	end

endmodule

// ===== rtl/knn_argmax.sv =====
// ----------------------------------------------------------------------------
// knn_argmax
// Pairwise max tree over the class counts; the lower class wins a tie.
// ----------------------------------------------------------------------------
module knn_argmax (
	input  knn_pkg::count_vec_t         votes,
	output logic [knn_pkg::LABEL_W-1:0] win_label,
	output logic [knn_pkg::CNT_W-1:0]   win_votes
);

	logic [knn_pkg::CNT_W-1:0]   cnt_l [knn_pkg::CLS_LVLS+1][knn_pkg::MAX_CLASSES];
	logic [knn_pkg::LABEL_W-1:0] idx_l [knn_pkg::CLS_LVLS+1][knn_pkg::MAX_CLASSES];

	always_comb begin
		for (int l = 0; l <= knn_pkg::CLS_LVLS; l++) begin
			for (int j = 0; j < knn_pkg::MAX_CLASSES; j++) begin
				cnt_l[l][j] = '0;
				idx_l[l][j] = '0;
			end
		end
		for (int j = 0; j < knn_pkg::MAX_CLASSES; j++) begin
			cnt_l[0][j] = votes[j];
			idx_l[0][j] = knn_pkg::LABEL_W'(j);
		end
		for (int l = 0; l < knn_pkg::CLS_LVLS; l++) begin
			for (int j = 0; j < (knn_pkg::MAX_CLASSES >> (l + 1)); j++) begin
				if (cnt_l[l][2*j+1] > cnt_l[l][2*j]) begin
					cnt_l[l+1][j] = cnt_l[l][2*j+1];
					idx_l[l+1][j] = idx_l[l][2*j+1];
				end else begin
					cnt_l[l+1][j] = cnt_l[l][2*j];
					idx_l[l+1][j] = idx_l[l][2*j];
				end
			end
		end
	end

	assign win_label = idx_l[knn_pkg::CLS_LVLS][0];
	assign win_votes = cnt_l[knn_pkg::CLS_LVLS][0];

endmodule

// ===== rtl/knn_top_k_vote_classifier_top.sv =====
// Path: a last item's result passes s1, s2, s3 and the output register.
// Throughput: one item per cycle; an item waits only while a last item sits
// in the input register and s2, s3 and the output are full with out_stall high.
// Rate is set by the combinational insert into the 8-entry list register.
// Reset: list empty, num_classes = 2, neighbor_count = 5, no result pending.
// ----------------------------------------------------------------------------
// knn_top_k_vote_classifier_top
// k-nearest-neighbor classifier: keeps the k smallest distances of a run and
// votes by class label on the last item.
// ----------------------------------------------------------------------------
module knn_top_k_vote_classifier_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          wr_en,
	input  logic [knn_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [knn_pkg::CFG_W-1:0]     wr_data,
	// candidate items
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [knn_pkg::DIST_W-1:0]    distance,
	input  logic [knn_pkg::LABEL_W-1:0]   neighbor_label,
	input  logic                          last,
	// results
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [knn_pkg::LABEL_W-1:0]   vote_label,
	output logic [knn_pkg::CNT_W-1:0]     winner_votes
);

	// ---------------- configuration ----------------
	logic [knn_pkg::NCLS_W-1:0] num_classes_q;
	logic [knn_pkg::NBR_W-1:0]  neighbor_count_q;
	logic [knn_pkg::CNT_W-1:0]  k_eff;
	logic [knn_pkg::NCLS_W-1:0] ncls_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_classes_q    <= knn_pkg::NUM_CLASSES_RST;
			neighbor_count_q <= knn_pkg::NEIGHBOR_COUNT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				knn_pkg::REG_NUM_CLASSES: begin
					num_classes_q <= wr_data[knn_pkg::NCLS_W-1:0];
				end
				knn_pkg::REG_NEIGHBOR_COUNT: begin
					neighbor_count_q <= wr_data[knn_pkg::NBR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// clamp both registers into their usable range
	always_comb begin
		if (neighbor_count_q == '0) begin
			k_eff = knn_pkg::CNT_W'(1);
		end else if (neighbor_count_q > knn_pkg::NBR_W'(knn_pkg::MAX_K)) begin
			k_eff = knn_pkg::CNT_W'(knn_pkg::MAX_K);
		end else begin
			k_eff = knn_pkg::CNT_W'(neighbor_count_q);
		end
		if (num_classes_q == '0) begin
			ncls_eff = knn_pkg::NCLS_W'(1);
		end else if (num_classes_q > knn_pkg::NCLS_W'(knn_pkg::MAX_CLASSES)) begin
			ncls_eff = knn_pkg::NCLS_W'(knn_pkg::MAX_CLASSES);
		end else begin
			ncls_eff = num_classes_q;
		end
	end

	// ---------------- pipeline control ----------------
	// Each stage moves when the stage after it is empty or moving. Only a
	// last item needs room in the vote stages, so a plain item in s1 always
	// goes into the list and never blocks the input.
	logic           s1_valid;
	knn_pkg::item_t s1_item;
	logic           s1_hold;
	logic           s1_fire;
	logic           s2_valid;
	logic           s2_ready;
	logic           s3_valid;
	logic           s3_ready;
	logic           out_ready;

	assign out_ready = !out_valid || !out_stall;
	assign s3_ready  = !s3_valid || out_ready;
	assign s2_ready  = !s2_valid || s3_ready;
	assign s1_hold   = s1_valid && s1_item.last && !s2_ready;
	assign s1_fire   = s1_valid && !s1_hold;
	assign in_stall  = s1_hold;

	// ---------------- s1: input register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (!s1_hold) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!s1_hold && in_valid) begin
			s1_item.distance <= distance;
			s1_item.label    <= neighbor_label;
			s1_item.last     <= last;
		end
	end

	// ---------------- sorted list ----------------
	knn_pkg::label_vec_t       snap_label;
	logic [knn_pkg::CNT_W-1:0] snap_count;

	knn_list u_list (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (s1_fire),
		.item       (s1_item),
		.k_eff      (k_eff),
		.snap_label (snap_label),
		.snap_count (snap_count)
	);

	// ---------------- s2: snapshot of the list after the last item ----------
	knn_pkg::label_vec_t       labels_s2;
	logic [knn_pkg::CNT_W-1:0] count_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (s2_ready) begin
			s2_valid <= s1_fire && s1_item.last;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && s1_fire && s1_item.last) begin
			labels_s2 <= snap_label;
			count_s2  <= snap_count;
		end
	end

	// ---------------- s3: per-class counts ----------------
	knn_pkg::count_vec_t votes;
	knn_pkg::count_vec_t votes_s3;

	knn_tally u_tally (
		.labels (labels_s2),
		.count  (count_s2),
		.ncls   (ncls_eff),
		.votes  (votes)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_valid <= 1'b0;
		end else if (s3_ready) begin
			s3_valid <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_ready && s2_valid) begin
			votes_s3 <= votes;
		end
	end

	// ---------------- output register: winning class ----------------
	logic [knn_pkg::LABEL_W-1:0] win_label;
	logic [knn_pkg::CNT_W-1:0]   win_votes;

	knn_argmax u_argmax (
		.votes     (votes_s3),
		.win_label (win_label),
		.win_votes (win_votes)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_ready) begin
			out_valid <= s3_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && s3_valid) begin
			vote_label   <= win_label;
			winner_votes <= win_votes;
		end
	end

endmodule

// ===== bench/knn_vote_checker.sv =====
// ----------------------------------------------------------------------------
// knn_vote_checker
// Watches the register port and both channels of the k-NN vote classifier,
// keeps its own sorted neighbor list, predicts each vote and compares it.
// ----------------------------------------------------------------------------
module knn_vote_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [knn_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [knn_pkg::CFG_W-1:0]     wr_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [knn_pkg::DIST_W-1:0]    distance,
	input  logic [knn_pkg::LABEL_W-1:0]   neighbor_label,
	input  logic                          last,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [knn_pkg::LABEL_W-1:0]   vote_label,
	input  logic [knn_pkg::CNT_W-1:0]     winner_votes,
	input  logic                          run_done,
	output int                            pending,
	output int                            votes_checked,
	output int                            failures
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [knn_pkg::LABEL_W-1:0] label;
		logic [knn_pkg::CNT_W-1:0]   votes;
	} verdict_t;

	logic [knn_pkg::DIST_W-1:0]  near_dist  [knn_pkg::MAX_K];
	logic [knn_pkg::LABEL_W-1:0] near_label [knn_pkg::MAX_K];
	int                          kept;
	logic [knn_pkg::NCLS_W-1:0]  cls_reg;
	logic [knn_pkg::NBR_W-1:0]   k_reg;
	verdict_t                    verdicts [$];
	int                          mismatches;

	assign failures = mismatches + (run_done ? pending : 0);

	// sampled mid-cycle: everything driven at the rising edge has settled,
	// and what is seen here is what the next rising edge takes
	always @(negedge clk) begin : predict
		int k, ncls, n, pos, win, i;
		int tally [knn_pkg::MAX_CLASSES];
		verdict_t want, got;
		if (!arst_n) begin
			kept = 0;
			cls_reg = knn_pkg::NUM_CLASSES_RST;
			k_reg = knn_pkg::NEIGHBOR_COUNT_RST;
			verdicts.delete();
			pending = 0;
			votes_checked = 0;
			mismatches = 0;
		end else begin
			// result side first: a result never belongs to an item of the same edge
			if (out_valid && !out_stall) begin
				got.label = vote_label;
				got.votes = winner_votes;
				if (verdicts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result label %0d votes %0d", $realtime,
							got.label, got.votes);
				end else begin
					want = verdicts.pop_front();
					pending--;
					votes_checked++;
					if (got.label !== want.label || got.votes !== want.votes) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: vote mismatch: expected label %0d votes %0d, ",
								"got label %0d votes %0d"},
								$realtime, want.label, want.votes, got.label, got.votes);
					end
				end
			end

			if (wr_en) begin
				if (wr_index == knn_pkg::REG_NUM_CLASSES)
					cls_reg = wr_data[knn_pkg::NCLS_W-1:0];
				else if (wr_index == knn_pkg::REG_NEIGHBOR_COUNT)
					k_reg = wr_data[knn_pkg::NBR_W-1:0];
			end

			if (in_valid && !in_stall) begin
				k = (k_reg == 0) ? 1 : (k_reg > knn_pkg::MAX_K) ? knn_pkg::MAX_K :
					int'(k_reg);
				n = (kept > k) ? k : kept;
				// ties go behind earlier entries
				pos = 0;
				while (pos < n && near_dist[pos] <= distance)
					pos++;
				if (pos >= k) begin
					kept = n;
				end else begin
					if (n == k)
						n = k - 1;
					for (i = n; i > pos; i--) begin
						near_dist[i] = near_dist[i-1];
						near_label[i] = near_label[i-1];
					end
					near_dist[pos] = distance;
					near_label[pos] = neighbor_label;
					kept = n + 1;
				end

				if (last) begin
					ncls = (cls_reg == 0) ? 1 :
						(cls_reg > knn_pkg::MAX_CLASSES) ? knn_pkg::MAX_CLASSES :
						int'(cls_reg);
					for (i = 0; i < knn_pkg::MAX_CLASSES; i++)
						tally[i] = 0;
					n = (kept > k) ? k : kept;
					for (i = 0; i < n; i++)
						if (near_label[i] < ncls)
							tally[near_label[i]]++;
					win = 0;
					for (i = 1; i < ncls; i++)
						if (tally[i] > tally[win])
							win = i;
					want.label = knn_pkg::LABEL_W'(win);
					want.votes = knn_pkg::CNT_W'((tally[win] > 15) ? 15 : tally[win]);
					verdicts.push_back(want);
					pending++;
					kept = 0;
				end
			end
		end
	end

endmodule

// ===== bench/tb_knn_top_k_vote_classifier_top.sv =====
// ----------------------------------------------------------------------------
// tb_knn_top_k_vote_classifier_top
// Drives runs of candidate transactions and register writes into the k-NN vote
// classifier, with random gaps on both channels, and reports the verdict of the
// checker that sits beside the block.
// ----------------------------------------------------------------------------
module tb_knn_top_k_vote_classifier_top;
	timeunit 1ns;
	timeprecision 1ps;

	// delay from a last item's transaction to its vote, through s1, s2, s3 and the output register
	localparam int DUT_LATENCY = 3;
	localparam int LONG_HOLD   = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int NUM_PHASES  = 12;
	localparam int PHASE_ITEMS = 127;

	logic                          clk;
	logic                          arst_n;
	logic                          wr_en;
	logic [knn_pkg::REG_IDX_W-1:0] wr_index;
	logic [knn_pkg::CFG_W-1:0]     wr_data;
	logic                          in_valid;
	logic                          in_stall;
	logic [knn_pkg::DIST_W-1:0]    distance;
	logic [knn_pkg::LABEL_W-1:0]   neighbor_label;
	logic                          last;
	logic                          out_valid;
	logic                          out_stall;
	logic [knn_pkg::LABEL_W-1:0]   vote_label;
	logic [knn_pkg::CNT_W-1:0]     winner_votes;

	logic run_done;
	int   pending, votes_checked, failures;

	// stimulus bookkeeping
	int         cycle_count = 0;
	int         items_sent;
	int         settings;
	int         hold_asked;
	int         hold_served = 0;
	bit         tx_quiet, rx_quiet;
	logic [knn_pkg::CFG_W-1:0] cls_now;

	knn_top_k_vote_classifier_top DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.distance        (distance),
		.neighbor_label  (neighbor_label),
		.last            (last),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.vote_label      (vote_label),
		.winner_votes    (winner_votes)
	);

	knn_vote_checker vote_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.distance        (distance),
		.neighbor_label  (neighbor_label),
		.last            (last),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.vote_label      (vote_label),
		.winner_votes    (winner_votes),
		.run_done        (run_done),
		.pending         (pending),
		.votes_checked   (votes_checked),
		.failures        (failures)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// hard stop in case a handshake never completes
	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d votes still pending", cycle_count, pending);
		$display("status: fail");
		$finish;
	end

	// Idle length: mostly zero or a few cycles, now and then a long stretch.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Result side: random stall runs, none while rx_quiet is set, and a long
	// counted hold-off whenever the stimulus asks for one.
	initial begin : rx_side
		int run_left;
		run_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_asked) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_served++;
				out_stall <= 1'b0;
			end else if (rx_quiet) begin
				out_stall <= 1'b0;
			end else if (run_left > 0) begin
				run_left--;
			end else begin
				out_stall <= ($urandom_range(0, 1) == 1);
				run_left = pick_gap();
			end
		end
	end

	// One candidate transaction. Called at a rising edge; returns at the edge
	// that took it. Stall is sampled mid-cycle, where it has settled.
	task automatic send_item(input logic [knn_pkg::DIST_W-1:0] d,
		input logic [knn_pkg::LABEL_W-1:0] lb, input logic lst);
		int gap;
		bit took;
		gap = tx_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			distance <= knn_pkg::DIST_W'($urandom);   // junk while valid is low
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		distance <= d;
		neighbor_label <= lb;
		last <= lst;
		do begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end while (!took);
		items_sent++;
	endtask

	// Stop sending, let every vote come out, then wait out the pipeline so the
	// block is quiet before a register write.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DUT_LATENCY + 2) @(posedge clk);
	endtask

	task automatic set_config(input logic [knn_pkg::CFG_W-1:0] cls,
		input logic [knn_pkg::CFG_W-1:0] kv);
		wr_en <= 1'b1;
		wr_index <= knn_pkg::REG_NUM_CLASSES;
		wr_data <= cls;
		@(posedge clk);
		wr_index <= knn_pkg::REG_NEIGHBOR_COUNT;
		wr_data <= kv;
		@(posedge clk);
		wr_en <= 1'b0;
		cls_now = cls;
		settings++;
	endtask

	// A run of random candidates, the last one flagged. Distance flavor is
	// picked per run: full range, dense ties, or hugging the extremes. Labels
	// stay mostly inside the class count so the votes mean something.
	task automatic send_run(input int len);
		int mode, lim, j;
		logic [knn_pkg::DIST_W-1:0]  d;
		logic [knn_pkg::LABEL_W-1:0] lb;
		mode = $urandom_range(0, 3);
		lim = (cls_now == 0) ? 1 :
			(cls_now > knn_pkg::MAX_CLASSES) ? knn_pkg::MAX_CLASSES : int'(cls_now);
		for (j = 0; j < len; j++) begin
			if (mode < 2)
				d = knn_pkg::DIST_W'($urandom_range(0, 16'hFFFF));
			else if (mode == 2)
				d = knn_pkg::DIST_W'($urandom_range(0, 7));
			else if ($urandom_range(0, 1) == 1)
				d = 16'hFFFF - knn_pkg::DIST_W'($urandom_range(0, 3));
			else
				d = knn_pkg::DIST_W'($urandom_range(0, 3));
			if ($urandom_range(0, 5) == 0)
				lb = knn_pkg::LABEL_W'($urandom_range(0, 15));
			else
				lb = knn_pkg::LABEL_W'($urandom_range(0, lim - 1));
			send_item(d, lb, j == len - 1);
		end
	endtask

	initial begin : stimulus
		int ph, r, len;
		logic [knn_pkg::CFG_W-1:0] cls, kv;

		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= knn_pkg::REG_NUM_CLASSES;
		wr_data <= '0;
		in_valid <= 1'b0;
		distance <= '0;
		neighbor_label <= '0;
		last <= 1'b0;
		run_done <= 1'b0;
		items_sent = 0;
		settings = 0;
		hold_asked = 0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		cls_now = knn_pkg::NUM_CLASSES_RST;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed, reset settings: 2 classes, k = 5 ---
		// single-item run
		send_item(16'h0000, 4'd0, 1'b1);
		// longer than k, with ties in arrival order, a label outside the classes
		// and late items that fall off the end of a full list
		send_item(16'd100, 4'd1, 1'b0);
		send_item(16'd100, 4'd0, 1'b0);
		send_item(16'hFFFF, 4'd1, 1'b0);
		send_item(16'h0000, 4'd1, 1'b0);
		send_item(16'd100, 4'd15, 1'b0);
		send_item(16'd50, 4'd1, 1'b0);
		send_item(16'd100, 4'd0, 1'b1);
		// every kept label outside the classes: no vote at all
		send_item(16'd5, 4'd15, 1'b0);
		send_item(16'd6, 4'd3, 1'b1);
		settle();

		// --- all 16 classes, k = 8: four-way tie goes to the lowest class ---
		set_config(5'd16, 5'd8);
		send_item(16'd10, 4'd7, 1'b0);
		send_item(16'd10, 4'd3, 1'b0);
		send_item(16'd20, 4'd7, 1'b0);
		send_item(16'd20, 4'd3, 1'b0);
		send_item(16'hFFFF, 4'd15, 1'b0);
		send_item(16'd1, 4'd15, 1'b0);
		send_item(16'd30, 4'd9, 1'b0);
		send_item(16'd40, 4'd9, 1'b0);
		send_item(16'hFFFF, 4'd0, 1'b1);

		// k shrinks from 8 to 2 in the middle of a run: only the two nearest
		// entries survive, and the closing item lands beyond them
		send_item(16'd40, 4'd1, 1'b0);
		send_item(16'd30, 4'd2, 1'b0);
		send_item(16'd20, 4'd3, 1'b0);
		send_item(16'd10, 4'd4, 1'b0);
		send_item(16'd50, 4'd5, 1'b0);
		settle();
		set_config(5'd16, 5'd2);
		send_item(16'd25, 4'd6, 1'b1);

		// --- random phases, each under its own register setting ---
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			// the sender pauses here until every vote is back
			settle();
			case (ph)
				0: begin cls = 5'd1;  kv = 5'd1;  end
				1: begin cls = 5'd16; kv = 5'd8;  end
				2: begin cls = 5'd0;  kv = 5'd0;  end
				3: begin cls = 5'd31; kv = 5'd15; end
				4: begin cls = 5'd17; kv = 5'd9;  end
				5: begin cls = 5'd2;  kv = 5'h13; end   // upper data bit is not part of k
				default: begin
					cls = ($urandom_range(0, 4) == 0) ?
						knn_pkg::CFG_W'($urandom_range(0, 31)) :
						knn_pkg::CFG_W'($urandom_range(1, 16));
					kv = knn_pkg::CFG_W'($urandom_range(0, 31));
				end
			endcase
			set_config(cls, kv);

			// every fourth phase runs back to back on both sides
			tx_quiet = (ph % 4 == 1);
			rx_quiet = (ph % 4 == 1);

			// back-pressure: results are held off for a long stretch while short
			// runs keep coming, so the block fills and stalls its input
			if (ph == 3 || ph == 8) begin
				hold_asked++;
				tx_quiet = 1'b1;
				repeat (60) send_run(1 + $urandom_range(0, 1));
				tx_quiet = 1'b0;
			end

			while (items_sent < 25 + (ph + 1) * PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 10)
					len = 1;
				else if (r < 75)
					len = $urandom_range(2, 10);
				else
					len = $urandom_range(11, 24);
				send_run(len);
			end
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;

		// drain, then give the pipeline time to show any stray result
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DUT_LATENCY + 8) @(posedge clk);
		run_done <= 1'b1;
		@(negedge clk);

		$display("covered %0d candidate transactions, %0d votes checked, %0d register settings",
			items_sent, votes_checked, settings);
		$display("incl. ties, out-of-range labels and registers, k cut mid-run, %0d hold-offs",
			hold_asked);
		if (failures == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d failures", failures);
			$display("status: fail");
		end
		$finish;
	end

endmodule
